[sv/allocation_range_checker_assert.svh]
`ifndef ALLOCATION_RANGE_CHECKER_ASSERT_SVH
`define ALLOCATION_RANGE_CHECKER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define ARC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("allocation_range_checker: assertion failed");

// next-cycle implication, disabled in reset
`define ARC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("allocation_range_checker: assertion failed");

`endif

[sv/arc_pkg.sv]
package arc_pkg;

	localparam int MAX_RANGES_DEF = 64;
	localparam int ADDR_WIDTH_DEF = 32;
	localparam int TAG_WIDTH_DEF  = 16;

	localparam int SIZE_WIDTH   = 32;
	localparam int ALIGN_WIDTH  = 3;
	localparam int FUNC_WIDTH   = 2;
	localparam int STATUS_WIDTH = 3;
	localparam int CFG_IDX_W    = 2;

	localparam logic [FUNC_WIDTH-1:0] FN_ADD    = 2'd0;
	localparam logic [FUNC_WIDTH-1:0] FN_REMOVE = 2'd1;
	localparam logic [FUNC_WIDTH-1:0] FN_CLEAR  = 2'd2;

	localparam logic [STATUS_WIDTH-1:0] STAT_OK         = 3'd0;
	localparam logic [STATUS_WIDTH-1:0] STAT_MISALIGNED = 3'd1;
	localparam logic [STATUS_WIDTH-1:0] STAT_OUTSIDE    = 3'd2;
	localparam logic [STATUS_WIDTH-1:0] STAT_OVERLAP    = 3'd3;
	localparam logic [STATUS_WIDTH-1:0] STAT_FULL       = 3'd4;
	localparam logic [STATUS_WIDTH-1:0] STAT_NOT_FOUND  = 3'd5;

	localparam logic [CFG_IDX_W-1:0] REG_HEAP_LOW   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEAP_HIGH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ALIGN_LOG2 = 2'd2;

	localparam logic [ALIGN_WIDTH-1:0] ALIGN_RESET = 3'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SCAN,
		ST_DONE
	} state_t;

	// flags of the search wave moving down the row
	typedef struct packed {
		logic active;
		logic ov;
		logic free;
		logic hit;
	} wave_t;

	// table update broadcast to every cell
	typedef struct packed {
		logic store;
		logic drop;
		logic wipe;
	} cmd_t;

endpackage

[sv/allocation_range_checker.sv]
// Range table of MAX_RANGES entries held in a row of cells, one entry per cell. One beat at a
// time: an add or a remove gives its result once the search wave has passed through every
// cell, stepping through one cell per cycle. A clear, an unused function code or an add that
// fails the alignment or window check gives its result from the check step, with no scan.
// Once the result is in the output register the block returns to idle for the next beat.
// A new beat is accepted while the previous result still waits on the output register. If a
// result is still unaccepted when the next one is ready, the next one holds in its last step.
// The user is to write configuration through cfg_we, cfg_index and cfg_data only while no
// beat is in flight; the block does not enforce this. Indexes beyond align_log2 are ignored.
module allocation_range_checker #(
	parameter int MAX_RANGES = arc_pkg::MAX_RANGES_DEF,
	parameter int ADDR_WIDTH = arc_pkg::ADDR_WIDTH_DEF,
	parameter int TAG_WIDTH  = arc_pkg::TAG_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [arc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ADDR_WIDTH-1:0]            cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [arc_pkg::FUNC_WIDTH-1:0]   func,
	input  logic [ADDR_WIDTH-1:0]            start_addr,
	input  logic [arc_pkg::SIZE_WIDTH-1:0]   block_size,
	input  logic [TAG_WIDTH-1:0]             tag,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [arc_pkg::STATUS_WIDTH-1:0] status,
	output logic [TAG_WIDTH-1:0]             conflict_tag
);
	import arc_pkg::*;

	localparam int IDX_W = $clog2(MAX_RANGES);
	localparam int CW    = (ADDR_WIDTH > SIZE_WIDTH) ? ADDR_WIDTH : SIZE_WIDTH;

	logic [ADDR_WIDTH-1:0]   heap_low_q;
	logic [ADDR_WIDTH-1:0]   heap_high_q;
	logic [ALIGN_WIDTH-1:0]  align_q;

	state_t                  state_q;
	state_t                  state_d;

	logic [FUNC_WIDTH-1:0]   func_q;
	logic [ADDR_WIDTH-1:0]   lo_q;
	logic [ADDR_WIDTH-1:0]   hi_q;
	logic [SIZE_WIDTH-1:0]   size_m1_q;
	logic                    size_zero_q;
	logic [TAG_WIDTH-1:0]    tag_q;

	logic [STATUS_WIDTH-1:0] res_status_q;
	logic [STATUS_WIDTH-1:0] res_status_d;
	logic [TAG_WIDTH-1:0]    res_ctag_q;
	logic [TAG_WIDTH-1:0]    res_ctag_d;
	logic                    res_load;

	logic                    out_valid_q;
	logic [STATUS_WIDTH-1:0] status_q;
	logic [TAG_WIDTH-1:0]    ctag_q;

	logic [ADDR_WIDTH-1:0]   amask;
	logic [ADDR_WIDTH-1:0]   lo_inv;
	logic                    misaligned;
	logic [CW-1:0]           hi_full;
	logic                    outside;
	logic                    launch;
	logic                    in_acc;
	logic                    out_free;

	cmd_t                    cmd;
	logic [IDX_W-1:0]        cmd_idx;

	wave_t                   wave     [MAX_RANGES+1];
	logic [TAG_WIDTH-1:0]    wave_otag[MAX_RANGES+1];
	logic [IDX_W-1:0]        wave_fidx[MAX_RANGES+1];
	logic [IDX_W-1:0]        wave_hidx[MAX_RANGES+1];
	wave_t                   wave_end;

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign wave_end = wave[MAX_RANGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_low_q  <= '0;
			heap_high_q <= '1;
			align_q     <= ALIGN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HEAP_LOW:   heap_low_q  <= cfg_data;
				REG_HEAP_HIGH:  heap_high_q <= cfg_data;
				REG_ALIGN_LOG2: align_q     <= cfg_data[ALIGN_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// last byte is ready before the wave enters the first cell
	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_q      <= func;
			lo_q        <= start_addr;
			hi_q        <= start_addr + ADDR_WIDTH'(block_size) - ADDR_WIDTH'(1);
			size_m1_q   <= block_size - SIZE_WIDTH'(1);
			size_zero_q <= (block_size == '0);
			tag_q       <= tag;
		end
		if (res_load) begin
			res_status_q <= res_status_d;
			res_ctag_q   <= res_ctag_d;
		end
	end

	always_comb begin
		amask      = ({{(ADDR_WIDTH-1){1'b0}}, 1'b1} << align_q) - ADDR_WIDTH'(1);
		misaligned = |(lo_q & amask);
		lo_inv     = ~lo_q;
		hi_full    = CW'(lo_q) + CW'(size_m1_q);
		outside    = size_zero_q || (CW'(size_m1_q) > CW'(lo_inv)) ||
		             (lo_q < heap_low_q) || (hi_full[ADDR_WIDTH-1:0] > heap_high_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		launch       = 1'b0;
		cmd          = '0;
		cmd_idx      = wave_fidx[MAX_RANGES];
		res_load     = 1'b0;
		res_status_d = STAT_OK;
		res_ctag_d   = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				res_load = 1'b1;
				state_d  = ST_DONE;
				case (func_q)
					FN_ADD: begin
						if (misaligned) begin
							res_status_d = STAT_MISALIGNED;
						end else if (outside) begin
							res_status_d = STAT_OUTSIDE;
						end else begin
							res_load = 1'b0;
							launch   = 1'b1;
							state_d  = ST_SCAN;
						end
					end
					FN_REMOVE: begin
						res_load = 1'b0;
						launch   = 1'b1;
						state_d  = ST_SCAN;
					end
					FN_CLEAR: begin
						cmd.wipe = 1'b1;
					end
					default: ;
				endcase
			end
			ST_SCAN: begin
				if (wave_end.active) begin
					res_load = 1'b1;
					state_d  = ST_DONE;
					if (func_q == FN_ADD) begin
						if (wave_end.ov) begin
							res_status_d = STAT_OVERLAP;
							res_ctag_d   = wave_otag[MAX_RANGES];
						end else if (!wave_end.free) begin
							res_status_d = STAT_FULL;
						end else begin
							cmd.store = 1'b1;
						end
					end else begin
						cmd_idx = wave_hidx[MAX_RANGES];
						if (wave_end.hit) begin
							cmd.drop = 1'b1;
						end else begin
							res_status_d = STAT_NOT_FOUND;
						end
					end
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			status_q <= res_status_q;
			ctag_q   <= res_ctag_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign conflict_tag = ctag_q;

	always_comb begin
		wave[0]        = '0;
		wave[0].active = launch;
		wave_otag[0]   = '0;
		wave_fidx[0]   = '0;
		wave_hidx[0]   = '0;
	end

	for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
		arc_cell #(
			.ADDR_WIDTH (ADDR_WIDTH),
			.TAG_WIDTH  (TAG_WIDTH),
			.IDX_W      (IDX_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.my_idx   (IDX_W'(i)),
			.req_lo   (lo_q),
			.req_hi   (hi_q),
			.req_tag  (tag_q),
			.cmd      (cmd),
			.cmd_idx  (cmd_idx),
			.wave_in  (wave[i]),
			.otag_in  (wave_otag[i]),
			.fidx_in  (wave_fidx[i]),
			.hidx_in  (wave_hidx[i]),
			.wave_out (wave[i+1]),
			.otag_out (wave_otag[i+1]),
			.fidx_out (wave_fidx[i+1]),
			.hidx_out (wave_hidx[i+1])
		);
	end

`include "allocation_range_checker_assert.svh"

	`ARC_ASSERT_NEXT(a_accept_check, clk, arst_n, in_acc, state_q == ST_CHECK)
	`ARC_ASSERT_NOW(a_wave_in_scan, clk, arst_n, wave_end.active, state_q == ST_SCAN)
	`ARC_ASSERT_NOW(a_cmd_onehot, clk, arst_n, 1'b1, $onehot0({cmd.store, cmd.drop, cmd.wipe}))
	`ARC_ASSERT_NOW(a_ctag_zero, clk, arst_n, out_valid && (status != STAT_OVERLAP),
		conflict_tag == '0)

endmodule

[sv/arc_cell.sv]
module arc_cell #(
	parameter int ADDR_WIDTH = 32,
	parameter int TAG_WIDTH  = 16,
	parameter int IDX_W      = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [IDX_W-1:0]      my_idx,
	input  logic [ADDR_WIDTH-1:0] req_lo,
	input  logic [ADDR_WIDTH-1:0] req_hi,
	input  logic [TAG_WIDTH-1:0]  req_tag,
	input  arc_pkg::cmd_t         cmd,
	input  logic [IDX_W-1:0]      cmd_idx,
	input  arc_pkg::wave_t        wave_in,
	input  logic [TAG_WIDTH-1:0]  otag_in,
	input  logic [IDX_W-1:0]      fidx_in,
	input  logic [IDX_W-1:0]      hidx_in,
	output arc_pkg::wave_t        wave_out,
	output logic [TAG_WIDTH-1:0]  otag_out,
	output logic [IDX_W-1:0]      fidx_out,
	output logic [IDX_W-1:0]      hidx_out
);
	import arc_pkg::*;

	logic                  valid_q;
	logic [ADDR_WIDTH-1:0] low_q;
	logic [ADDR_WIDTH-1:0] high_q;
	logic [TAG_WIDTH-1:0]  tag_q;

	wave_t                 wave_q;
	logic [TAG_WIDTH-1:0]  otag_q;
	logic [IDX_W-1:0]      fidx_q;
	logic [IDX_W-1:0]      hidx_q;

	logic                  ovl;
	logic                  match;
	logic                  sel;

	always_comb begin
		ovl   = valid_q && (req_lo <= high_q) && (req_hi >= low_q);
		match = valid_q && (low_q == req_lo);
		sel   = (cmd_idx == my_idx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.wipe) begin
			valid_q <= 1'b0;
		end else if (cmd.store && sel) begin
			valid_q <= 1'b1;
		end else if (cmd.drop && sel) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store && sel && !cmd.wipe) begin
			low_q  <= req_lo;
			high_q <= req_hi;
			tag_q  <= req_tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_q <= '0;
		end else begin
			wave_q.active <= wave_in.active;
			wave_q.ov     <= wave_in.ov | ovl;
			wave_q.free   <= wave_in.free | !valid_q;
			wave_q.hit    <= wave_in.hit | match;
		end
	end

	// earlier cells win: keep what arrives once its flag is set
	always_ff @(posedge clk) begin
		otag_q <= wave_in.ov   ? otag_in : tag_q;
		fidx_q <= wave_in.free ? fidx_in : my_idx;
		hidx_q <= wave_in.hit  ? hidx_in : my_idx;
	end

	assign wave_out = wave_q;
	assign otag_out = otag_q;
	assign fidx_out = fidx_q;
	assign hidx_out = hidx_q;

endmodule
